>>> sv/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> sv/e2q_pkg.sv
// types and constants for the euler to quaternion block
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int ATAN_ENTRIES = 24;
    localparam int CW = 28;
    localparam logic signed [27:0] INV_GAIN = 28'sd10188014;
    localparam logic signed [27:0] PI_Q24 = 28'sd52707179;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [18:0] OUT_MAX = 19'sd16384;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } quat_t;

    // arctangent of 2^-i in q.24
    function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
        logic signed [27:0] r;
        case (i)
            5'd0: r = 28'sd13176795;
            5'd1: r = 28'sd7778716;
            5'd2: r = 28'sd4110060;
            5'd3: r = 28'sd2086331;
            5'd4: r = 28'sd1047214;
            5'd5: r = 28'sd524117;
            5'd6: r = 28'sd262123;
            5'd7: r = 28'sd131069;
            5'd8: r = 28'sd65536;
            5'd9: r = 28'sd32768;
            5'd10: r = 28'sd16384;
            5'd11: r = 28'sd8192;
            5'd12: r = 28'sd4096;
            5'd13: r = 28'sd2048;
            5'd14: r = 28'sd1024;
            5'd15: r = 28'sd512;
            5'd16: r = 28'sd256;
            5'd17: r = 28'sd128;
            5'd18: r = 28'sd64;
            5'd19: r = 28'sd32;
            5'd20: r = 28'sd16;
            5'd21: r = 28'sd8;
            5'd22: r = 28'sd4;
            5'd23: r = 28'sd2;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction
endpackage

>>> sv/euler_to_quaternion.sv
// euler angle to quaternion pipeline
//
// one transaction: drive roll, pitch and yaw (q2.14 radians) in angles
// and pulse start; busy is always low, so a transaction may start in
// every cycle. the quaternion (q1.14, saturated to +-1.0) appears on
// result with done high for one cycle; one result per cycle sustained.
// the pipe is the cordic stage chain (one stage per micro-rotation)
// followed by the product stages.
// reset clears only the valid bits; nothing is lost or repeated since
// the receiver cannot stall the pipe, so it simply flows.
// stages: fold, cordic x n, cosine sign, ab products, abc products,
// sums, round and clamp.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  e2q_pkg::angles_t angles,
    output logic done,
    output e2q_pkg::quat_t result
);
    localparam int NS = (CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
                        CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES;
    localparam int CW = e2q_pkg::CW;

    assign busy = 1'b0;

    // cordic stage chain, entry 0 is loaded by the fold stage
    logic signed [CW-1:0] cx_reg [NS+1][3], cy_reg [NS+1][3], cz_reg [NS+1][3];
    logic cn_reg [NS+1][3];
    logic cv_reg [NS+1];

    // fold stage
    logic signed [15:0] ang_in [3];
    assign ang_in[0] = angles.roll_angle;
    assign ang_in[1] = angles.pitch_angle;
    assign ang_in[2] = angles.yaw_angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else
            cv_reg[0] <= start;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [CW-1:0] a;
            a = {{(CW-26){ang_in[k][15]}}, ang_in[k], 10'd0};
            cx_reg[0][k] <= e2q_pkg::INV_GAIN;
            cy_reg[0][k] <= '0;
            if (a > e2q_pkg::HALF_PI_Q24)
            begin
                cz_reg[0][k] <= e2q_pkg::PI_Q24 - a;
                cn_reg[0][k] <= 1'b1;
            end
            else if (a < -e2q_pkg::HALF_PI_Q24)
            begin
                cz_reg[0][k] <= -e2q_pkg::PI_Q24 - a;
                cn_reg[0][k] <= 1'b1;
            end
            else
            begin
                cz_reg[0][k] <= a;
                cn_reg[0][k] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else
                cv_reg[i+1] <= cv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [CW-1:0] dx, dy, at;
                dx = cy_reg[i][k] >>> i;
                dy = cx_reg[i][k] >>> i;
                at = e2q_pkg::atan_q24(5'(i));
                if (!cz_reg[i][k][CW-1])
                begin
                    cx_reg[i+1][k] <= cx_reg[i][k] - dx;
                    cy_reg[i+1][k] <= cy_reg[i][k] + dy;
                    cz_reg[i+1][k] <= cz_reg[i][k] - at;
                end
                else
                begin
                    cx_reg[i+1][k] <= cx_reg[i][k] + dx;
                    cy_reg[i+1][k] <= cy_reg[i][k] - dy;
                    cz_reg[i+1][k] <= cz_reg[i][k] + at;
                end
                cn_reg[i+1][k] <= cn_reg[i][k];
            end
        end
    end

    // cosine sign, values fit in 26 bits
    logic signed [25:0] c_reg [3], s_reg [3];
    logic vs_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_reg[k] <= cn_reg[NS][k] ? 26'(-cx_reg[NS][k]) : 26'(cx_reg[NS][k]);
            s_reg[k] <= 26'(cy_reg[NS][k]);
        end
    end

    // first products rounded to q.24: cr*cp, sr*sp, sr*cp, cr*sp
    logic signed [25:0] ab_reg [4];
    logic signed [25:0] cy2_reg, sy2_reg;
    logic vab_reg;
    function automatic logic signed [25:0] mulr(input logic signed [25:0] a,
                                               input logic signed [25:0] b);
        logic signed [51:0] p;
        p = a * b + 52'sd8388608;
        return 26'(p >>> 24);
    endfunction
    always_ff @(posedge clk)
    begin
        ab_reg[0] <= mulr(c_reg[0], c_reg[1]);
        ab_reg[1] <= mulr(s_reg[0], s_reg[1]);
        ab_reg[2] <= mulr(s_reg[0], c_reg[1]);
        ab_reg[3] <= mulr(c_reg[0], s_reg[1]);
        cy2_reg <= c_reg[2];
        sy2_reg <= s_reg[2];
    end

    // triple products in q.48
    logic signed [51:0] t_reg [8];
    logic vt_reg;
    always_ff @(posedge clk)
    begin
        t_reg[0] <= ab_reg[2] * cy2_reg;
        t_reg[1] <= ab_reg[3] * sy2_reg;
        t_reg[2] <= ab_reg[3] * cy2_reg;
        t_reg[3] <= ab_reg[2] * sy2_reg;
        t_reg[4] <= ab_reg[0] * sy2_reg;
        t_reg[5] <= ab_reg[1] * cy2_reg;
        t_reg[6] <= ab_reg[0] * cy2_reg;
        t_reg[7] <= ab_reg[1] * sy2_reg;
    end

    // component sums
    logic signed [52:0] sum_reg [4];
    logic vsum_reg;
    always_ff @(posedge clk)
    begin
        sum_reg[0] <= 53'(t_reg[0]) - 53'(t_reg[1]);
        sum_reg[1] <= 53'(t_reg[2]) + 53'(t_reg[3]);
        sum_reg[2] <= 53'(t_reg[4]) - 53'(t_reg[5]);
        sum_reg[3] <= 53'(t_reg[6]) + 53'(t_reg[7]);
    end

    // round and clamp
    logic signed [15:0] q_next [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic signed [52:0] r;
            r = (sum_reg[k] + 53'sd8589934592) >>> 34;
            if (r > 53'(e2q_pkg::OUT_MAX))
                q_next[k] = 16'sd16384;
            else if (r < -53'(e2q_pkg::OUT_MAX))
                q_next[k] = -16'sd16384;
            else
                q_next[k] = 16'(r);
        end
    end

    e2q_pkg::quat_t result_reg;
    logic done_reg;
    always_ff @(posedge clk)
    begin
        result_reg.quat_x <= q_next[0];
        result_reg.quat_y <= q_next[1];
        result_reg.quat_z <= q_next[2];
        result_reg.quat_w <= q_next[3];
    end

    // valid chain through the product stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= 1'b0;
            vab_reg <= 1'b0;
            vt_reg <= 1'b0;
            vsum_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vs_reg <= cv_reg[NS];
            vab_reg <= vs_reg;
            vt_reg <= vab_reg;
            vsum_reg <= vt_reg;
            done_reg <= vsum_reg;
        end
    end

    assign done = done_reg;
    assign result = result_reg;

    `ASSERT_NEXT(a_start_flows, clk, rst_n, start, cv_reg[0])
    `ASSERT_NEXT(a_done_follows, clk, rst_n, vsum_reg, done)
    `ASSERT_IMPLIES(a_w_range, clk, rst_n, done,
        (result.quat_w <= 16'sd16384) && (result.quat_w >= -16'sd16384))
endmodule
